// ===== rtl/core/ps2m_pkg.sv =====
//------------------------------------------------------------------------------
// ps2m_pkg
// Shared constants, types and the initialization command table for the
// PS/2 mouse host controller.
//------------------------------------------------------------------------------
`default_nettype none

package ps2m_pkg;

  localparam int unsigned CommandCountDefault = 13;
  localparam int unsigned PosWidthDefault     = 32;
  localparam int unsigned RomDepth            = 16;

  localparam logic [7:0] DelayReset = 8'd12;

  // Event codes carried on op.
  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpRxByte = 2'd1;
  localparam logic [1:0] OpClkLow = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] CmdReset    = 8'hFF;
  localparam logic [7:0] CmdReadType = 8'hF2;
  localparam logic [7:0] CmdEnable   = 8'hF4;
  localparam logic [7:0] RspAck      = 8'hFA;
  localparam logic [7:0] RspResend   = 8'hFE;
  localparam logic [7:0] RspError    = 8'hFC;
  localparam logic [7:0] RspSelfTest = 8'hAA;
  localparam logic [7:0] RspDevId    = 8'h00;

  // Register index of send_delay_ticks.
  localparam logic RegSendDelay = 1'b0;

  // One received byte handed to the packet assembler.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } pkt_req_t;

  // Initialization command table; entries past the real list enable reporting.
  function automatic logic [7:0] init_rom(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'hF3;
      4'd1:    b = 8'hC8;
      4'd2:    b = 8'hF3;
      4'd3:    b = 8'h64;
      4'd4:    b = 8'hF3;
      4'd5:    b = 8'h50;
      4'd6:    b = CmdReadType;
      4'd7:    b = 8'hE8;
      4'd8:    b = 8'h03;
      4'd9:    b = 8'hE6;
      4'd10:   b = 8'hF3;
      4'd11:   b = 8'h28;
      default: b = CmdEnable;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ps2m_pkt.sv =====
//------------------------------------------------------------------------------
// ps2m_pkt
// Packet assembler: syncs on bit 3 of the first byte, collects 4-byte
// packets and keeps buttons, wrapping positions and last nonzero moves.
//------------------------------------------------------------------------------
`default_nettype none

module ps2m_pkt
  import ps2m_pkg::*;
#(
  parameter int unsigned POS_WIDTH = PosWidthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pkt_req_t                    req_i,
  output logic                             done_o,
  output logic [2:0]                       buttons_o,
  output logic signed [POS_WIDTH-1:0]      x_acc_o,
  output logic signed [POS_WIDTH-1:0]      y_acc_o,
  output logic signed [POS_WIDTH-1:0]      z_acc_o,
  output logic signed [7:0]                last_x_o,
  output logic signed [7:0]                last_y_o
);

  logic [1:0]                   slot_q, slot_d;
  logic [7:0]                   store_q [3];
  logic [2:0]                   buttons_q;
  logic signed [POS_WIDTH-1:0]  x_q, y_q, z_q;
  logic signed [7:0]            last_x_q, last_y_q;
  logic                         take, finish;
  logic signed [7:0]            xs, ys, zs;

  assign xs = signed'(store_q[1]);
  assign ys = signed'(store_q[2]);
  assign zs = signed'(req_i.data);

  // A first byte without the always-one bit is dropped to regain sync.
  assign take   = req_i.valid && !(slot_q == 2'd0 && !req_i.data[3]);
  assign finish = take && (slot_q == 2'd3);

  always_comb begin
    slot_d = slot_q;
    if (take) begin
      slot_d = slot_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !finish) begin
      store_q[slot_q] <= req_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= 2'd0;
      buttons_q <= 3'd0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      last_x_q  <= 8'sd0;
      last_y_q  <= 8'sd0;
    end else begin
      slot_q <= slot_d;
      if (finish) begin
        buttons_q <= store_q[0][2:0];
        x_q       <= x_q + POS_WIDTH'(xs);
        y_q       <= y_q + POS_WIDTH'(ys);
        z_q       <= z_q + POS_WIDTH'(zs);
        if (xs != 8'sd0) begin
          last_x_q <= xs;
        end
        if (ys != 8'sd0) begin
          last_y_q <= ys;
        end
      end
    end
  end

  assign done_o    = finish;
  assign buttons_o = buttons_q;
  assign x_acc_o   = x_q;
  assign y_acc_o   = y_q;
  assign z_acc_o   = z_q;
  assign last_x_o  = last_x_q;
  assign last_y_o  = last_y_q;

endmodule

`default_nettype wire

// ===== rtl/core/ps2_mouse_host_init_and_packet.sv =====
//------------------------------------------------------------------------------
// ps2_mouse_host_init_and_packet
// Byte-level PS/2 mouse host: reset handshake, table-driven initialization,
// device type capture and 4-byte packet decoding.
//------------------------------------------------------------------------------
// The result of an accepted request is loaded into the output
// register. Throughput: one request per cycle; the input stalls only while a
// result is held back by out_stall_i. All state updates for a request are
// done in the cycle it is accepted. Reset (rst_ni low, asynchronous) returns
// to startup with positions and status cleared and send_delay_ticks at 12.
//------------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_host_init_and_packet
  import ps2m_pkg::*;
#(
  parameter int unsigned COMMAND_COUNT = CommandCountDefault,
  parameter int unsigned POS_WIDTH     = PosWidthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // Event input
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [7:0]         rx_byte_i,
  // Result output
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    tx_valid_o,
  output logic [7:0]              tx_byte_o,
  output logic                    initialized_o,
  output logic [7:0]              device_id_o,
  output logic [2:0]              buttons_o,
  output logic                    packet_done_o,
  output logic signed [31:0]      x_total_o,
  output logic signed [31:0]      y_total_o,
  output logic signed [31:0]      z_total_o,
  output logic signed [7:0]       last_x_step_o,
  output logic signed [7:0]       last_y_step_o
);

  localparam int unsigned PtrWidth = $clog2(COMMAND_COUNT + 1);

  typedef enum logic [3:0] {
    PhStartup,
    PhResetAck,
    PhWaitAa,
    PhWait00,
    PhWaitClk,
    PhDelay,
    PhAck,
    PhDevType,
    PhRun
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [PtrWidth-1:0]   ptr_q, ptr_d;
  logic [7:0]            sent_q, sent_d;
  logic [7:0]            type_q, type_d;
  logic [7:0]            tick_q, tick_d;
  logic [7:0]            delay_q;
  logic                  out_valid_q;
  logic                  tx_valid_q, tx_valid_d;
  logic [7:0]            tx_byte_q, tx_byte_d;
  logic                  done_q;
  logic                  accept;
  logic                  issue;
  logic [PtrWidth-1:0]   issue_ptr;
  logic [7:0]            rom_byte;
  pkt_req_t              pkt_req;
  logic                  pkt_done;
  logic signed [POS_WIDTH-1:0] x_acc, y_acc, z_acc;
  logic signed [63:0]    x_ext, y_ext, z_ext;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSendDelay) ? {24'd0, delay_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegSendDelay) begin
      delay_q <= pwdata[7:0];
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign rom_byte = init_rom(4'(issue_ptr));

  // Sequencer. An issue either sends a table entry (the next, or the same
  // on a resend) or, past the end of the table, enters the running phase.
  always_comb begin
    phase_d    = phase_q;
    ptr_d      = ptr_q;
    sent_d     = sent_q;
    type_d     = type_q;
    tick_d     = tick_q;
    tx_valid_d = 1'b0;
    tx_byte_d  = 8'd0;
    issue      = 1'b0;
    issue_ptr  = ptr_q;
    pkt_req    = '{valid: 1'b0, data: rx_byte_i};

    if (phase_q == PhStartup) begin
      tx_valid_d = 1'b1;
      tx_byte_d  = CmdReset;
      ptr_d      = '0;
      phase_d    = PhResetAck;
    end else if (op_i == OpRxByte) begin
      unique case (phase_q)
        PhResetAck: if (rx_byte_i == RspAck) phase_d = PhWaitAa;
        PhWaitAa:   if (rx_byte_i == RspSelfTest) phase_d = PhWait00;
        PhWait00:   if (rx_byte_i == RspDevId) phase_d = PhWaitClk;
        PhAck: begin
          priority if (rx_byte_i == RspAck) begin
            ptr_d = ptr_q + PtrWidth'(1);
            if (sent_q == CmdReadType) begin
              phase_d = PhDevType;
            end else begin
              issue     = 1'b1;
              issue_ptr = ptr_q + PtrWidth'(1);
            end
          end else if (rx_byte_i == RspResend) begin
            issue = 1'b1;
          end else if (rx_byte_i == RspError) begin
            tx_valid_d = 1'b1;
            tx_byte_d  = CmdReset;
            ptr_d      = '0;
            phase_d    = PhResetAck;
          end else begin
            phase_d = phase_q;
          end
        end
        PhDevType: begin
          type_d = rx_byte_i;
          issue  = 1'b1;
        end
        PhRun:     pkt_req.valid = 1'b1;
        default:   phase_d = phase_q;
      endcase
    end else if (op_i == OpClkLow) begin
      if (phase_q == PhWaitClk) begin
        tick_d  = delay_q;
        phase_d = PhDelay;
      end
    end else if (op_i == OpTick) begin
      if (phase_q == PhDelay) begin
        if (tick_q == 8'd0) begin
          ptr_d     = '0;
          issue     = 1'b1;
          issue_ptr = '0;
        end else begin
          tick_d = tick_q - 8'd1;
        end
      end
    end

    if (issue) begin
      if (32'(issue_ptr) >= COMMAND_COUNT) begin
        phase_d = PhRun;
      end else begin
        sent_d     = rom_byte;
        tx_valid_d = 1'b1;
        tx_byte_d  = rom_byte;
        phase_d    = PhAck;
      end
    end

    if (!accept) begin
      pkt_req.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStartup;
      ptr_q       <= '0;
      sent_q      <= 8'd0;
      type_q      <= 8'd0;
      tick_q      <= 8'd0;
      out_valid_q <= 1'b0;
      tx_valid_q  <= 1'b0;
      tx_byte_q   <= 8'd0;
      done_q      <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        ptr_q      <= ptr_d;
        sent_q     <= sent_d;
        type_q     <= type_d;
        tick_q     <= tick_d;
        tx_valid_q <= tx_valid_d;
        tx_byte_q  <= tx_byte_d;
        done_q     <= pkt_done;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  ps2m_pkt #(
    .POS_WIDTH(POS_WIDTH)
  ) u_pkt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (pkt_req),
    .done_o   (pkt_done),
    .buttons_o(buttons_o),
    .x_acc_o  (x_acc),
    .y_acc_o  (y_acc),
    .z_acc_o  (z_acc),
    .last_x_o (last_x_step_o),
    .last_y_o (last_y_step_o)
  );

  // Positions are reported sign-extended (or truncated) to 32 bits. State
  // only changes on an accepted request, so while a result waits the status
  // fields still show the values that belong to it.
  assign x_ext = 64'(x_acc);
  assign y_ext = 64'(y_acc);
  assign z_ext = 64'(z_acc);

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = tx_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign initialized_o = (phase_q == PhRun);
  assign device_id_o   = type_q;
  assign packet_done_o = done_q;
  assign x_total_o     = x_ext[31:0];
  assign y_total_o     = y_ext[31:0];
  assign z_total_o     = z_ext[31:0];

endmodule

`default_nettype wire
